// ===== design/box_downsample_2x2_defines.svh =====
// ----------------------------------------------------------------------------
// box_downsample_2x2_defines.svh
// assertion macros used by the checker file of the 2x2 downsampler
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// fixed field widths, register codes and reset values of the 2x2 downsampler
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int PAIR_W     = 9;
    localparam int SUM_W      = 10;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int NCH_W      = 3;
    localparam int CH_W       = 2;

    localparam int SIZE_MIN   = 2;
    localparam int HEIGHT_MAX = 4096;

    localparam logic [CFG_W-1:0] WIDTH_RESET    = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET   = CFG_W'(480);
    localparam logic [NCH_W-1:0] CHANNELS_RESET = NCH_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } t_cfg_index;

endpackage

// ===== design/bds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/box_downsample_2x2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-filter downsampler for an interleaved 8-bit sample stream
// ----------------------------------------------------------------------------
// Takes one channel sample per clock while o_stall is low, in raster order,
// and emits, for every 2x2 pixel block, the floor of the mean of its four
// samples per channel. An output beat passes the s1 and out registers after
// the beat that completes its block. Even rows store horizontal pair sums in
// a line ram of (MAX_WIDTH/2)*MAX_CHANNELS x 9 bits, odd rows read them back
// (one ram access per beat), so the line ram port sets the rate. The line
// ram is not cleared after reset. A write to the width, height or channel
// register restarts the frame at row zero, column zero, channel zero. An odd
// last column or row is accepted and dropped.
// ----------------------------------------------------------------------------
module box_downsample_2x2
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SAMPLE_W-1:0]  o_pixel_value,
    output logic [CH_W-1:0]      o_channel_index,
    output logic                 o_row_end,
    output logic                 o_frame_end
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration
    logic [CFG_W-1:0]  r_cfg_width;
    logic [CFG_W-1:0]  r_cfg_height;
    logic [NCH_W-1:0]  r_cfg_channels;
    logic              cfg_hit;

    // effective geometry
    logic [WW-1:0]       width_eff;
    logic [WW-1:0]       width_even;
    logic [WW-1:0]       width_m1;
    logic [WW-1:0]       last_col;
    logic [HEIGHT_W-1:0] height_eff;
    logic [HEIGHT_W-1:0] height_even;
    logic [ROW_W-1:0]    height_m1;
    logic [ROW_W-1:0]    last_row;
    logic [NCH_W-1:0]    nch_eff;
    logic [CH_W-1:0]     nch_m1;

    // position counters
    logic [CW-1:0]    r_col;
    logic [CH_W-1:0]  r_ch;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    n_col;
    logic [CH_W-1:0]  n_ch;
    logic [ROW_W-1:0] n_row;
    logic [AW-1:0]    n_base;

    // datapath
    logic [SAMPLE_W-1:0] r_left [MAX_CHANNELS];
    logic                accept;
    logic                advance;
    logic                in_range;
    logic                ch_last;
    logic                col_last;
    logic                is_row_end;
    logic                produce;
    logic                store;
    logic [PAIR_W-1:0]   pair;
    logic [AW-1:0]       line_addr;
    logic [PAIR_W-1:0]   line_rdata;
    logic [SUM_W-1:0]    total;

    logic                r_s1_valid;
    logic [PAIR_W-1:0]   r_s1_pair;
    logic [CH_W-1:0]     r_s1_ch;
    logic                r_s1_row_end;
    logic                r_s1_frame_end;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_pixel;
    logic [CH_W-1:0]     r_out_ch;
    logic                r_out_row_end;
    logic                r_out_frame_end;

    // register clamps
    always_comb begin
        if (32'(r_cfg_width) < SIZE_MIN) begin
            width_eff = WW'(SIZE_MIN);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_cfg_width);
        end
        if (32'(r_cfg_height) < SIZE_MIN) begin
            height_eff = HEIGHT_W'(SIZE_MIN);
        end else if (32'(r_cfg_height) > HEIGHT_MAX) begin
            height_eff = HEIGHT_W'(HEIGHT_MAX);
        end else begin
            height_eff = r_cfg_height;
        end
        if (r_cfg_channels == '0) begin
            nch_eff = NCH_W'(1);
        end else if (32'(r_cfg_channels) > MAX_CHANNELS) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = r_cfg_channels;
        end
        width_even  = {width_eff[WW-1:1], 1'b0};
        width_m1    = width_eff - WW'(1);
        last_col    = width_even - WW'(1);
        height_even = {height_eff[HEIGHT_W-1:1], 1'b0};
        height_m1   = ROW_W'(height_eff - HEIGHT_W'(1));
        last_row    = ROW_W'(height_even - HEIGHT_W'(1));
        nch_m1      = CH_W'(nch_eff - NCH_W'(1));
    end

    // handshake
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !advance;
    assign accept  = i_valid && !o_stall;

    // position and pair sum
    always_comb begin
        ch_last    = (r_ch == nch_m1);
        col_last   = (WW'(r_col) == width_m1);
        in_range   = (WW'(r_col) <= last_col) && (r_row <= last_row);
        is_row_end = ch_last && (WW'(r_col) == last_col);
        produce    = accept && in_range && r_col[0] && r_row[0];
        store      = accept && in_range && r_col[0] && !r_row[0];
        pair       = PAIR_W'(r_left[r_ch[LW-1:0]]) + PAIR_W'(i_sample);
        line_addr  = r_base + AW'(r_ch);

        n_col  = r_col;
        n_ch   = r_ch;
        n_row  = r_row;
        n_base = r_base;
        if (ch_last) begin
            n_ch = '0;
            if (col_last) begin
                n_col  = '0;
                n_base = '0;
                n_row  = (r_row == height_m1) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
                if (r_col[0]) begin
                    n_base = r_base + AW'(nch_eff);
                end
            end
        end else begin
            n_ch = r_ch + CH_W'(1);
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT
                                  || i_cfg_index == CFG_CHANNELS);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= WIDTH_RESET;
            r_cfg_height   <= HEIGHT_RESET;
            r_cfg_channels <= CHANNELS_RESET;
            r_col          <= '0;
            r_ch           <= '0;
            r_row          <= '0;
            r_base         <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_WIDTH:    r_cfg_width    <= i_cfg_data;
                    CFG_HEIGHT:   r_cfg_height   <= i_cfg_data;
                    CFG_CHANNELS: r_cfg_channels <= i_cfg_data[NCH_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_col  <= '0;
                r_ch   <= '0;
                r_row  <= '0;
                r_base <= '0;
            end else if (accept) begin
                r_col  <= n_col;
                r_ch   <= n_ch;
                r_row  <= n_row;
                r_base <= n_base;
            end
            if (advance || !r_s1_valid) begin
                r_s1_valid <= produce;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && in_range && !r_col[0]) begin
            r_left[r_ch[LW-1:0]] <= i_sample;
        end
        if (advance || !r_s1_valid) begin
            r_s1_pair      <= pair;
            r_s1_ch        <= r_ch;
            r_s1_row_end   <= is_row_end;
            r_s1_frame_end <= is_row_end && (r_row == last_row);
        end
        if (advance && r_s1_valid) begin
            r_out_pixel     <= total[SUM_W-1:2];
            r_out_ch        <= r_s1_ch;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign total = SUM_W'(line_rdata) + SUM_W'(r_s1_pair);

    bds_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (line_addr),
        .i_wdata (pair),
        .i_re    (produce),
        .i_raddr (line_addr),
        .o_rdata (line_rdata)
    );

    assign o_valid         = r_out_valid;
    assign o_pixel_value   = r_out_pixel;
    assign o_channel_index = r_out_ch;
    assign o_row_end       = r_out_row_end;
    assign o_frame_end     = r_out_frame_end;

endmodule

// ===== design/bds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_checker
// port-level checks of the 2x2 downsampler, bound to the top level
// ----------------------------------------------------------------------------
`include "box_downsample_2x2_defines.svh"

module bds_checker
    import bds_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [SAMPLE_W-1:0]  o_pixel_value,
    input logic [CH_W-1:0]      o_channel_index,
    input logic                 o_row_end,
    input logic                 o_frame_end
);

    logic [SAMPLE_W+CH_W+1:0] out_beat;
    logic                     in_beat;

    assign out_beat = {o_pixel_value, o_channel_index, o_row_end, o_frame_end};
    assign in_beat  = i_valid && !o_stall;

    // stalled output beat holds
    `BDS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_beat), "stalled beat changed")

    // input stall only when a beat waits at the output
    `BDS_ASSERT_SAME(a_stall_needs_out, o_stall, o_valid && i_stall, "stall without blocked output")

    // a fresh output beat follows an accepted input beat through the s1 and out registers
    `BDS_ASSERT_SAME(a_out_latency, $rose(o_valid), $past(in_beat, 2), "output beat without input")

    // frame end marks the end of a row
    `BDS_ASSERT_SAME(a_frame_end_row, o_valid && o_frame_end, o_row_end, "frame end without row end")

endmodule

bind box_downsample_2x2 bds_checker u_bds_checker (.*);

// ===== sim/bds_mean_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_mean_checker
// watches both channels of the 2x2 downsampler and checks every output beat
// ----------------------------------------------------------------------------
// Keeps its own copy of the register settings, the position counters, the
// per-channel left samples and the line of pair sums. Each accepted sample
// beat advances that copy; a completed 2x2 block queues the expected mean
// with its channel and end flags. Each accepted output beat is compared
// field by field with the oldest queued mean.
// ----------------------------------------------------------------------------
module bds_mean_checker
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_sample_valid,
    input  logic                 i_sample_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_px_valid,
    input  logic                 i_px_stall,
    input  logic [SAMPLE_W-1:0]  i_px_value,
    input  logic [CH_W-1:0]      i_px_channel,
    input  logic                 i_px_row_end,
    input  logic                 i_px_frame_end,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic [CH_W-1:0]     chan;
        logic                row_end;
        logic                frame_end;
    } t_px_beat;

    t_px_beat            expected_means[$];
    logic [PAIR_W-1:0]   pair_line [0:LINE_DEPTH-1];
    logic [SAMPLE_W-1:0] left_store [0:MAX_CHANNELS-1];
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [NCH_W-1:0]    channels_reg;
    int unsigned         col_pos;
    int unsigned         ch_pos;
    int unsigned         row_pos;
    int                  fails;
    int                  checked;

    initial begin
        fails        = 0;
        checked      = 0;
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned w;
        int unsigned h;
        int unsigned nch;
        int unsigned col;
        int unsigned chn;
        int unsigned row;
        int unsigned last_col;
        int unsigned last_row;
        int unsigned pair;
        int unsigned idx;
        int unsigned total;
        t_px_beat    e;
        w        = clamp_to(width_reg, SIZE_MIN, MAX_WIDTH);
        h        = clamp_to(height_reg, SIZE_MIN, HEIGHT_MAX);
        nch      = clamp_to(channels_reg, 1, MAX_CHANNELS);
        col      = col_pos;
        chn      = ch_pos;
        row      = row_pos;
        last_col = 2 * (w / 2) - 1;
        last_row = 2 * (h / 2) - 1;
        if (col >= w) col = 0;
        if (chn >= nch) chn = 0;
        if (row >= h) row = 0;
        if (col <= last_col && row <= last_row) begin
            if (col % 2 == 0) begin
                left_store[chn] = s;
            end else begin
                pair = left_store[chn] + s;
                idx  = (col / 2) * nch + chn;
                if (row % 2 == 0) begin
                    pair_line[idx] = PAIR_W'(pair);
                end else begin
                    total       = pair_line[idx] + pair;
                    e.pixel     = SAMPLE_W'(total >> 2);
                    e.chan      = CH_W'(chn);
                    e.row_end   = (chn == nch - 1) && (col == last_col);
                    e.frame_end = e.row_end && (row == last_row);
                    expected_means.push_back(e);
                end
            end
        end
        chn++;
        if (chn >= nch) begin
            chn = 0;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        end
        col_pos = col;
        ch_pos  = chn;
        row_pos = row;
    endtask

    task automatic check_px_beat();
        t_px_beat e;
        if (expected_means.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("[%0t] unexpected output beat: value %0d channel %0d", $time,
                         i_px_value, i_px_channel);
            return;
        end
        e = expected_means.pop_front();
        checked++;
        if (e.pixel !== i_px_value || e.chan !== i_px_channel ||
            e.row_end !== i_px_row_end || e.frame_end !== i_px_frame_end) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("[%0t] mismatch: exp value %0d ch %0d row_end %0b frame_end %0b, got value %0d ch %0d row_end %0b frame_end %0b",
                         $time, e.pixel, e.chan, e.row_end, e.frame_end,
                         i_px_value, i_px_channel, i_px_row_end, i_px_frame_end);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg    = WIDTH_RESET;
            height_reg   = HEIGHT_RESET;
            channels_reg = CHANNELS_RESET;
            col_pos      = 0;
            ch_pos       = 0;
            row_pos      = 0;
            expected_means.delete();
        end else begin
            if (i_px_valid && !i_px_stall)
                check_px_beat();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH: begin
                        width_reg = i_cfg_data;
                        col_pos = 0; ch_pos = 0; row_pos = 0;
                    end
                    CFG_HEIGHT: begin
                        height_reg = i_cfg_data;
                        col_pos = 0; ch_pos = 0; row_pos = 0;
                    end
                    CFG_CHANNELS: begin
                        channels_reg = NCH_W'(i_cfg_data);
                        col_pos = 0; ch_pos = 0; row_pos = 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_sample_valid && !i_sample_stall)
                predict_sample(i_sample);
        end
        o_pending    <= expected_means.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the 2x2 box-filter downsampler
// ----------------------------------------------------------------------------
// Starts with short hand-picked frames (full-scale samples, clamped register
// values, odd width and height, a write to the unused register index), then
// runs random frame settings with random content, cut-off frames and
// random gaps and backpressure on both channels, and ends with the first
// samples of a frame whose width is clamped to the line store. Checking is
// done by bds_mean_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import bds_pkg::*;

    localparam int                   RANDOM_ITEMS  = 1200;
    localparam int                   WIDE_SAMPLES  = 64;
    localparam int                   SETTLE_CYCLES = 10;
    localparam int                   IDLE_LIMIT    = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [SAMPLE_W-1:0]  o_pixel_value;
    logic [CH_W-1:0]      o_channel_index;
    logic                 o_row_end;
    logic                 o_frame_end;

    int fail_count;
    int pending;
    int checked;
    int samples_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;
    bit rx_quiet = 1'b0;

    box_downsample_2x2 uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_value   (o_pixel_value),
        .o_channel_index (o_channel_index),
        .o_row_end       (o_row_end),
        .o_frame_end     (o_frame_end)
    );

    bds_mean_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_valid),
        .i_sample_stall (o_stall),
        .i_sample       (i_sample),
        .i_px_valid     (o_valid),
        .i_px_stall     (i_stall),
        .i_px_value     (o_pixel_value),
        .i_px_channel   (o_channel_index),
        .i_px_row_end   (o_row_end),
        .i_px_frame_end (o_frame_end),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    // receiver backpressure
    initial begin
        int free_len;
        int stall_len;
        int r;
        forever begin
            i_stall <= 1'b0;
            free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (rx_quiet) stall_len = 0;
            else if (r < 60) stall_len = $urandom_range(1, 2);
            else if (r < 92) stall_len = $urandom_range(3, 8);
            else stall_len = $urandom_range(20, 50);
            repeat (free_len) @(posedge i_clk);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // watchdog on beats of any kind
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
    endtask

    // sender holds off until every queued mean has come out
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0]  w_val;
        logic [CFG_W-1:0]  h_val;
        logic [NCH_W-1:0]  c_val;
        int unsigned       row_len;
        int unsigned       frame_len;
        int                n;
        int                pause_at;
        int                first;
        int                r;
        int                random_sent;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clamped minimum sizes, full-scale samples and a frame wrap
        write_reg(CFG_WIDTH, CFG_W'(1));
        write_reg(CFG_HEIGHT, CFG_W'(0));
        write_reg(CFG_CHANNELS, CFG_W'(0));
        i_cfg_we <= 1'b0;
        settings_used++;
        for (int k = 0; k < 4; k++) send_sample(8'hff);
        for (int k = 0; k < 4; k++) send_sample(8'h00);
        settle();

        // odd width and odd height, then an unused register index mid-frame
        write_reg(CFG_WIDTH, CFG_W'(3));
        write_reg(CFG_HEIGHT, CFG_W'(3));
        write_reg(CFG_CHANNELS, CFG_W'(1));
        i_cfg_we <= 1'b0;
        settings_used++;
        for (int k = 0; k < 9; k++) send_sample((k % 2 == 0) ? 8'hff : 8'h01);
        for (int k = 0; k < 5; k++) send_sample(pick_sample());
        settle();
        write_reg(CFG_SPARE, '1);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 4; k++) send_sample(pick_sample());
        settle();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) w_val = CFG_W'($urandom_range(2, 8));
            else if (r < 88) w_val = CFG_W'($urandom_range(9, 24));
            else w_val = CFG_W'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 80) h_val = CFG_W'($urandom_range(2, 6));
            else if (r < 92) h_val = CFG_W'($urandom_range(0, 1));
            else h_val = CFG_W'($urandom_range(4097, 8191));
            r = $urandom_range(0, 99);
            if (r < 80) c_val = NCH_W'($urandom_range(1, 4));
            else if (r < 88) c_val = '0;
            else c_val = NCH_W'($urandom_range(5, 7));

            first = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) begin
                case ((first + k) % 3)
                    0: write_reg(CFG_WIDTH, w_val);
                    1: write_reg(CFG_HEIGHT, h_val);
                    default: write_reg(CFG_CHANNELS, CFG_W'(c_val));
                endcase
            end
            i_cfg_we <= 1'b0;
            settings_used++;

            row_len   = clamp_to(w_val, SIZE_MIN, 4096) * clamp_to(c_val, 1, 4);
            frame_len = row_len * clamp_to(h_val, SIZE_MIN, HEIGHT_MAX);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, 2 * row_len);
            else
                n = frame_len * $urandom_range(1, 2) + $urandom_range(0, 2 * row_len);
            if (n > 400) n = 400 - $urandom_range(0, 120);
            pause_at   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : -1;
            burst_mode = ($urandom_range(0, 3) == 0);
            rx_quiet   = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < n; k++) begin
                if (k == pause_at) settle();
                send_sample(pick_sample());
            end
            random_sent += n;
            settle();
        end

        // width clamped to the line store, start of the first row only
        burst_mode = 1'b0;
        rx_quiet   = 1'b0;
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, CFG_W'(1));
        write_reg(CFG_CHANNELS, CFG_W'(1));
        i_cfg_we <= 1'b0;
        settings_used++;
        for (int k = 0; k < WIDE_SAMPLES; k++) send_sample(pick_sample());
        settle();

        $display("covered %0d sample beats over %0d frame settings", samples_sent,
                 settings_used);
        $display("compared %0d output beats, %0d failed", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bds_pkg.sv
design/bds_ram.sv
design/box_downsample_2x2.sv
design/bds_checker.sv
sim/bds_mean_checker.sv
sim/tb_top.sv
